@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/atbm_pkg.sv @@
// types, constants and the arctangent table of the tilt baseline monitor
// no dependencies
package atbm_pkg;

    localparam int RAW_W       = 16;
    localparam int ANGLE_W     = 17;
    localparam int THR_W       = 8;
    localparam int DP_W        = 28;   // cordic x/y datapath
    localparam int ACC_W       = 26;   // angle accumulator, 1/65536 degree
    localparam int TAB_LEN     = 24;
    localparam int TAB_IDX_W   = 5;
    localparam int TAB_W       = 22;
    localparam int SCALE_SHIFT = 8;
    localparam int ROUND_SHIFT = 9;

    localparam logic [THR_W-1:0]          THR_RESET    = 8'd30;
    localparam logic signed [ACC_W-1:0]   ACC_QUARTER  = 26'sd5898240;
    localparam logic signed [ACC_W:0]     ROUND_HALF   = 27'sd256;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 17'sd11520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN    = -17'sd34560;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX    = 17'sd11520;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] num;
        logic [RAW_W-1:0] den;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] angle;
    } cordic_res_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/atbm_in_if.sv @@
// sample channel: valid/ready handshake with three raw acceleration words
// depends on atbm_pkg
interface atbm_in_if;
    import atbm_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

@@ hdl/atbm_out_if.sv @@
// result channel: valid/ready handshake with two tilt angles and four flags
// depends on atbm_pkg
interface atbm_out_if;
    import atbm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic                      over_pos_x;
    logic                      over_neg_x;
    logic                      over_pos_y;
    logic                      over_neg_y;

    modport source (output valid, output angle_x, output angle_y, output over_pos_x,
                    output over_neg_x, output over_pos_y, output over_neg_y, input ready);
    modport sink   (input valid, input angle_x, input angle_y, input over_pos_x,
                    input over_neg_x, input over_pos_y, input over_neg_y, output ready);
endinterface

@@ hdl/accel_tilt_baseline_monitor.sv @@
// top level of the accelerometer tilt baseline monitor
// depends on atbm_pkg, atbm_in_if, atbm_out_if, atbm_cordic and assert_macros.svh
`include "assert_macros.svh"

// Takes one accelerometer sample (x, y, z, two's complement words) per transfer and returns
// one result transfer holding angle_x = atan2(z, y) - 90 deg and angle_y = atan2(z, x) - 90 deg
// in 1/128 degree, plus over/under flags against a baseline latched from the first sample
// after reset (that sample's flags are all zero). Both angles come from one shared cordic that
// performs a single micro-rotation per cycle, first for angle_x then for angle_y, and sample.ready
// stays low while a sample occupies the block. A finished result sits in an output register, so the next
// sample can be taken while it waits. tilt_threshold (whole degrees, reset 30) is written
// through cfg_we / cfg_wdata and should only change while the block is idle.
module accel_tilt_baseline_monitor #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [atbm_pkg::THR_W-1:0] cfg_wdata,
    atbm_in_if.sink                  sample,
    atbm_out_if.source               result
);
    import atbm_pkg::*;

    localparam int CMP_W = ANGLE_W + 2;

    // sequencer: x angle, y angle, then hand over to the output register
    typedef enum logic [1:0] {S_IDLE, S_ANG_X, S_ANG_Y, S_DONE} state_t;

    state_t                    state_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [RAW_W-1:0]          x_reg, z_reg;
    logic signed [ANGLE_W-1:0] ang_x_reg, ang_y_reg;
    logic                      base_taken_reg;
    logic signed [ANGLE_W-1:0] base_x_reg, base_y_reg;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_x_reg, out_y_reg;
    logic                      pos_x_reg, neg_x_reg, pos_y_reg, neg_y_reg;

    cordic_req_t req;
    cordic_res_t res;

    logic                      accept;
    logic signed [ANGLE_W-1:0] bx, by;
    logic signed [CMP_W-1:0]   thr_s, ax_s, ay_s, bx_s, by_s;
    logic                      pos_x, neg_x, pos_y, neg_y;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    // the cordic is fed straight from the port for angle_x, from the held sample for angle_y
    assign req.start = accept || ((state_reg == S_ANG_X) && res.done);
    assign req.num   = (state_reg == S_IDLE) ? sample.raw_z : z_reg;
    assign req.den   = (state_reg == S_IDLE) ? sample.raw_y : x_reg;

    atbm_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // baseline compare; before the baseline is taken the sample is its own baseline
    always_comb
    begin
        bx    = base_taken_reg ? base_x_reg : ang_x_reg;
        by    = base_taken_reg ? base_y_reg : ang_y_reg;
        thr_s = $signed({{(CMP_W-THR_W-7){1'b0}}, thr_reg, 7'b0});
        ax_s  = CMP_W'(ang_x_reg);
        ay_s  = CMP_W'(ang_y_reg);
        bx_s  = CMP_W'(bx);
        by_s  = CMP_W'(by);
        pos_x = ax_s > (bx_s + thr_s);
        neg_x = ax_s < (bx_s - thr_s);
        pos_y = ay_s > (by_s + thr_s);
        neg_y = ay_s < (by_s - thr_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THR_RESET;
            base_taken_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            x_reg          <= '0;
            z_reg          <= '0;
            ang_x_reg      <= '0;
            ang_y_reg      <= '0;
            base_x_reg     <= '0;
            base_y_reg     <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            pos_x_reg      <= 1'b0;
            neg_x_reg      <= 1'b0;
            pos_y_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;

            // result transfer frees the output register, unless a new result takes its place
            if (out_valid_reg && result.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg     <= sample.raw_x;
                        z_reg     <= sample.raw_z;
                        state_reg <= S_ANG_X;
                    end
                end
                S_ANG_X:
                begin
                    if (res.done)
                    begin
                        ang_x_reg <= res.angle;
                        state_reg <= S_ANG_Y;
                    end
                end
                S_ANG_Y:
                begin
                    if (res.done)
                    begin
                        ang_y_reg <= res.angle;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // wait for a free output register
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= ang_x_reg;
                        out_y_reg     <= ang_y_reg;
                        pos_x_reg     <= pos_x;
                        neg_x_reg     <= neg_x;
                        pos_y_reg     <= pos_y;
                        neg_y_reg     <= neg_y;
                        if (!base_taken_reg)
                        begin
                            base_taken_reg <= 1'b1;
                            base_x_reg     <= ang_x_reg;
                            base_y_reg     <= ang_y_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.angle_x    = out_x_reg;
    assign result.angle_y    = out_y_reg;
    assign result.over_pos_x = pos_x_reg;
    assign result.over_neg_x = neg_x_reg;
    assign result.over_pos_y = pos_y_reg;
    assign result.over_neg_y = neg_y_reg;

    // cordic only finishes while the sequencer waits for it
    `ASSERT_IMP(a_done_in_angle_state, res.done, state_reg == S_ANG_X || state_reg == S_ANG_Y)
    // the x angle is always followed by the y angle
    `ASSERT_NXT(a_x_then_y, state_reg == S_ANG_X && res.done, state_reg == S_ANG_Y)
    // an angle cannot lie both above and below its band
    `ASSERT_IMP(a_flags_excl_x, result.valid, !(result.over_pos_x && result.over_neg_x))
    `ASSERT_IMP(a_flags_excl_y, result.valid, !(result.over_pos_y && result.over_neg_y))
    // saturation keeps angle_x in range
    `ASSERT_IMP(a_angle_x_range, result.valid, result.angle_x >= ANGLE_MIN && result.angle_x <= ANGLE_MAX)

endmodule

@@ hdl/atbm_cordic.sv @@
// iterative vectoring cordic: atan2(num, den) - 90 degrees in 1/128 degree
// one micro-rotation per cycle; depends on atbm_pkg
module atbm_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  atbm_pkg::cordic_req_t req,
    output atbm_pkg::cordic_res_t res
);
    import atbm_pkg::*;

    localparam int ITER  = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER - 1);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W+1)'(ANGLE_MIN);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(ANGLE_MAX);
    localparam logic signed [ACC_W:0] QTR    = (ACC_W+1)'(QUARTER_TURN);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

    cstate_t                   state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [DP_W-1:0]    x_reg, y_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      zero_reg;
    logic                      done_reg;
    logic signed [ANGLE_W-1:0] angle_reg;

    logic signed [DP_W-1:0]    xs, ys, x_load, y_load;
    logic signed [ACC_W-1:0]   acc_load;
    logic signed [DP_W-1:0]    dx, dy, x_next, y_next;
    logic signed [ACC_W-1:0]   tab_s, acc_next;
    logic signed [ACC_W:0]     rsum, rq;
    logic signed [ANGLE_W-1:0] angle_next;

    // operand load with quarter-turn pre-rotation for a negative denominator
    always_comb
    begin
        xs = {{(DP_W-RAW_W-SCALE_SHIFT){req.den[RAW_W-1]}}, req.den, {SCALE_SHIFT{1'b0}}};
        ys = {{(DP_W-RAW_W-SCALE_SHIFT){req.num[RAW_W-1]}}, req.num, {SCALE_SHIFT{1'b0}}};
        x_load   = xs;
        y_load   = ys;
        acc_load = '0;
        if (xs[DP_W-1])
        begin
            if (!ys[DP_W-1])
            begin
                x_load   = ys;
                y_load   = -xs;
                acc_load = ACC_QUARTER;
            end
            else
            begin
                x_load   = -ys;
                y_load   = xs;
                acc_load = -ACC_QUARTER;
            end
        end
    end

    // one micro-rotation
    always_comb
    begin
        dx    = y_reg >>> cnt_reg;
        dy    = x_reg >>> cnt_reg;
        tab_s = $signed({{(ACC_W-TAB_W){1'b0}}, atan_entry(TAB_IDX_W'(cnt_reg))});
        if (!y_reg[DP_W-1] && (y_reg != '0))
        begin
            x_next   = x_reg + dx;
            y_next   = y_reg - dy;
            acc_next = acc_reg + tab_s;
        end
        else
        begin
            x_next   = x_reg - dx;
            y_next   = y_reg + dy;
            acc_next = acc_reg - tab_s;
        end
    end

    // round to 1/128 degree, remove the quarter turn, saturate; a zero input vector gives -90 degrees
    always_comb
    begin
        rsum = {acc_reg[ACC_W-1], acc_reg} + ROUND_HALF;
        rq   = (rsum >>> ROUND_SHIFT) - QTR;
        if (zero_reg)
            angle_next = -QUARTER_TURN;
        else if (rq < SAT_LO)
            angle_next = ANGLE_MIN;
        else if (rq > SAT_HI)
            angle_next = ANGLE_MAX;
        else
            angle_next = rq[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            zero_reg  <= 1'b0;
            done_reg  <= 1'b0;
            angle_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        x_reg     <= x_load;
                        y_reg     <= y_load;
                        acc_reg   <= acc_load;
                        zero_reg  <= (req.num == '0) && (req.den == '0);
                        cnt_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    x_reg   <= x_next;
                    y_reg   <= y_next;
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                        state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    angle_reg <= angle_next;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.angle = angle_reg;

endmodule

@@ verif/tilt_result_checker.sv @@
// result checker of the tilt baseline monitor: predicts each result and compares it
// depends on atbm_pkg, atbm_in_if and atbm_out_if
`timescale 1ns / 1ps

module tilt_result_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [atbm_pkg::THR_W-1:0] cfg_wdata,
    atbm_in_if                         sample,
    atbm_out_if                        result,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);
    import atbm_pkg::*;

    localparam int ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [ANGLE_W-1:0] ang_x;
        logic signed [ANGLE_W-1:0] ang_y;
        logic                      pos_x;
        logic                      neg_x;
        logic                      pos_y;
        logic                      neg_y;
    } tilt_result_t;

    tilt_result_t expected_tilts[$];
    logic [THR_W-1:0] threshold;
    bit               baseline_seen;
    int               base_x;
    int               base_y;
    int               fails;
    int               n_checked;

    // atan2(num, den) less a quarter turn, 1/128 degree, saturated
    function automatic int cordic_angle(input int num, input int den);
        longint xv, yv, acc, dx, dy, r;
        if (num == 0 && den == 0)
            return -int'(QUARTER_TURN);
        xv  = longint'(den) <<< SCALE_SHIFT;
        yv  = longint'(num) <<< SCALE_SHIFT;
        acc = 0;
        // left half plane: pre-rotate by a quarter turn
        if (xv < 0)
        begin
            dx = xv;
            if (yv >= 0)
            begin
                xv  = yv;
                yv  = -dx;
                acc = longint'(ACC_QUARTER);
            end
            else
            begin
                xv  = -yv;
                yv  = dx;
                acc = -longint'(ACC_QUARTER);
            end
        end
        for (int i = 0; i < ITERS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv  += dx;
                yv  -= dy;
                acc += ATAN_STEP[i];
            end
            else
            begin
                xv  -= dx;
                yv  += dy;
                acc -= ATAN_STEP[i];
            end
        end
        r = ((acc + 256) >>> ROUND_SHIFT) - longint'(QUARTER_TURN);
        if (r < longint'(ANGLE_MIN))
            r = longint'(ANGLE_MIN);
        if (r > longint'(ANGLE_MAX))
            r = longint'(ANGLE_MAX);
        return int'(r);
    endfunction

    function automatic tilt_result_t predict_tilt(input logic [RAW_W-1:0] wx,
                                                  input logic [RAW_W-1:0] wy,
                                                  input logic [RAW_W-1:0] wz);
        tilt_result_t t;
        int vx, vy, vz, ax, ay, margin;
        vx = $signed(wx);
        vy = $signed(wy);
        vz = $signed(wz);
        ax = cordic_angle(vz, vy);
        ay = cordic_angle(vz, vx);
        margin = int'(threshold) * 128;
        if (!baseline_seen)
        begin
            baseline_seen = 1'b1;
            base_x = ax;
            base_y = ay;
        end
        t.ang_x = ANGLE_W'(ax);
        t.ang_y = ANGLE_W'(ay);
        t.pos_x = (ax > base_x + margin);
        t.neg_x = (ax < base_x - margin);
        t.pos_y = (ay > base_y + margin);
        t.neg_y = (ay < base_y - margin);
        return t;
    endfunction

    function automatic bit field_ok(input string name, input logic signed [31:0] want,
                                    input logic signed [31:0] got);
        if (want === got)
            return 1'b1;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tilt_result_t want;
        bit ok;
        if (!rst_n)
        begin
            threshold     = THR_RESET;
            baseline_seen = 1'b0;
            base_x        = 0;
            base_y        = 0;
            fails         = 0;
            n_checked     = 0;
            expected_tilts.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_tilts.size() == 0)
                begin
                    $error("result transfer with no sample outstanding: angle_x %0d angle_y %0d",
                           result.angle_x, result.angle_y);
                    fails++;
                end
                else
                begin
                    want = expected_tilts.pop_front();
                    ok = field_ok("angle_x", want.ang_x, result.angle_x)
                       & field_ok("angle_y", want.ang_y, result.angle_y)
                       & field_ok("over_pos_x", want.pos_x, result.over_pos_x)
                       & field_ok("over_neg_x", want.neg_x, result.over_neg_x)
                       & field_ok("over_pos_y", want.pos_y, result.over_pos_y)
                       & field_ok("over_neg_y", want.neg_y, result.over_neg_y);
                    if (!ok)
                        fails++;
                    n_checked++;
                end
            end
            if (cfg_we)
                threshold = cfg_wdata;
            if (sample.valid && sample.ready)
                expected_tilts.push_back(predict_tilt(sample.raw_x, sample.raw_y, sample.raw_z));
        end
        fail_count <= fails;
        pending    <= expected_tilts.size();
        checked    <= n_checked;
    end

endmodule

@@ verif/testbench.sv @@
// top of the tilt baseline monitor testbench: clock, reset, stimulus and verdict
// depends on atbm_pkg, atbm_in_if, atbm_out_if, accel_tilt_baseline_monitor and tilt_result_checker
`timescale 1ns / 1ps

module testbench;
    import atbm_pkg::*;

    localparam int STEPS        = 16;
    // cycles one sample keeps the block busy: two cordic runs plus overhead
    localparam int BLOCK_CYCLES = 2 * ((STEPS < TAB_LEN) ? STEPS : TAB_LEN) + 5;
    localparam int PHASE_ITEMS  = 200;
    localparam int N_PHASES     = 8;
    localparam int HOLD_AFTER   = 450;  // results taken before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int samples_sent;
    int settings_used;
    bit steady;         // when set neither side inserts random idle gaps

    atbm_in_if  sample_if ();
    atbm_out_if result_if ();

    accel_tilt_baseline_monitor #(
        .CORDIC_STEPS (STEPS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_if),
        .result    (result_if)
    );

    // watches both channels and the register port, predicts and compares
    tilt_result_checker #(
        .CORDIC_STEPS (STEPS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample     (sample_if),
        .result     (result_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int idle_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // one acceleration word: full range, near zero, the extremes, or zero
    function automatic logic [RAW_W-1:0] random_word();
        logic [RAW_W-1:0] w;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            w = RAW_W'($urandom);
        else if (r < 70)
            w = RAW_W'($urandom_range(0, 16) - 8);
        else if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       w = 16'h8000;
                1:       w = 16'h7fff;
                2:       w = 16'hffff;
                3:       w = 16'h0001;
                default: w = 16'h8001;
            endcase
        end
        else
            w = '0;
        return w;
    endfunction

    // offer one sample after an optional gap and hold it until the transfer
    task automatic send_sample(input logic [RAW_W-1:0] wx, input logic [RAW_W-1:0] wy,
                               input logic [RAW_W-1:0] wz);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.raw_x <= wx;
        sample_if.raw_y <= wy;
        sample_if.raw_z <= wz;
        do
            @(posedge clk);
        while (!sample_if.ready);
        samples_sent++;
    endtask

    // drain the block, then change the threshold while it is idle
    task automatic write_threshold(input logic [THR_W-1:0] value);
        sample_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // stimulus: directed samples at the reset threshold, then random phases
    initial
    begin : stimulus
        logic [RAW_W-1:0] directed [0:15][0:2];
        logic [THR_W-1:0] thr_plan [0:N_PHASES-1];
        int drain;

        // every block input known from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        sample_if.valid = 1'b0;
        sample_if.raw_x = '0;
        sample_if.raw_y = '0;
        sample_if.raw_z = '0;
        samples_sent    = 0;
        settings_used   = 1;
        steady          = 1'b0;

        // x, y, z; the first one becomes the baseline (z straight down, angles near -180 deg)
        directed = '{
            '{16'h0000, 16'h0000, 16'hc000},
            '{16'h0000, 16'h0000, 16'h0000},  // both operands zero on both angles
            '{16'h7fff, 16'h7fff, 16'h7fff},
            '{16'h8000, 16'h8000, 16'h8000},
            '{16'h8000, 16'h7fff, 16'h0000},  // angle_y at its upper limit
            '{16'h7fff, 16'h8000, 16'hffff},  // angle_x close to its lower limit
            '{16'h0000, 16'h0000, 16'h7fff},
            '{16'h0001, 16'hffff, 16'h0001},
            '{16'hffff, 16'h0001, 16'h8000},
            '{16'h8000, 16'h0000, 16'h8000},
            '{16'h7fff, 16'h8000, 16'h0001},  // negative den, positive num: pre-rotation
            '{16'h1234, 16'hedcb, 16'h5a5a},
            '{16'h0000, 16'h0000, 16'h8000},
            '{16'h8000, 16'h7fff, 16'h7fff},
            '{16'hc000, 16'h4000, 16'h0000},
            '{16'h0000, 16'hffff, 16'hfffe}
        };

        // threshold per random phase: both extremes, beyond 180, and back to reset value
        thr_plan = '{8'd0, 8'd180, 8'd255, 8'd1, 8'd0, 8'd30, 8'd0, 8'd45};
        thr_plan[4] = THR_W'($urandom_range(2, 179));
        thr_plan[6] = THR_W'($urandom_range(0, 255));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_sample(directed[i][0], directed[i][1], directed[i][2]);

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_threshold(thr_plan[p]);
            // a couple of phases run with no random idle gaps on either side
            steady = (p == 2) || (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_word(), random_word(), random_word());
        end
        steady = 1'b0;
        sample_if.valid <= 1'b0;

        // wait for the outstanding results, bounded
        drain = 0;
        do
        begin
            @(posedge clk);
            drain++;
        end
        while (pending != 0 && drain < 20 * BLOCK_CYCLES + 2 * HOLD_CYCLES);
        repeat (2 * BLOCK_CYCLES) @(posedge clk);

        if (pending != 0)
            $error("%0d expected results never arrived", pending);

        $display("run covered %0d samples under %0d threshold settings", samples_sent,
                 settings_used);
        $display("%0d results compared field by field, %0d failed", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver: short and long stalls after transfers, plus one long hold-off that
    // fills the block so that it must stall its sample input
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int taken;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        taken      = 0;
        hold_done  = 1'b0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                taken++;
                stall_left = idle_gap();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (!hold_done && taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                result_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // watchdog well above the slowest legal run
    initial
    begin : watchdog
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/atbm_pkg.sv
hdl/atbm_in_if.sv
hdl/atbm_out_if.sv
hdl/atbm_cordic.sv
hdl/accel_tilt_baseline_monitor.sv
verif/tilt_result_checker.sv
verif/testbench.sv
